// ===== sv/ktc_pkg.sv =====
package ktc_pkg;

  localparam int TEMP_W   = 16;
  localparam int LUM_W    = 32;
  localparam int OUT_W    = 16;
  localparam int UV_FRAC  = 32;
  localparam int PW       = 60;
  localparam int DSW      = 39;
  localparam int DW       = 38;

  localparam logic [TEMP_W-1:0] T_MIN = 16'd1000;
  localparam logic [TEMP_W-1:0] T_MAX = 16'd15000;

  // rational coefficients scaled by 10^15
  localparam logic [PW-1:0] SCALE_ONE = 60'd1000000000000000;
  localparam logic [PW-1:0] UN0 = 60'd860117757000000;
  localparam logic [PW-1:0] UN1 = 60'd154118254000;
  localparam logic [PW-1:0] UN2 = 60'd128641210;
  localparam logic [PW-1:0] UD1 = 60'd842420235000;
  localparam logic [PW-1:0] UD2 = 60'd708145163;
  localparam logic [PW-1:0] VN0 = 60'd317398726000000;
  localparam logic [PW-1:0] VN1 = 60'd42280624500;
  localparam logic [PW-1:0] VN2 = 60'd42048169;
  localparam logic [PW-1:0] VD1 = 60'd28974181600;
  localparam logic [PW-1:0] VD2 = 60'd161456053;

  localparam logic [DSW-1:0] D_TWELVE = DSW'(12) << UV_FRAC;

endpackage

// ===== sv/kelvin_to_chromaticity.sv =====
// throughput: one beat per cycle; the whole pipeline holds while the result is stalled
// depth is set by the 32 bit-per-stage u/v divide and the CHROMA_FRAC_BITS-stage x/y divide
// reset: synchronous active-high rst clears all stage valid bits; data registers are not reset
module kelvin_to_chromaticity
  import ktc_pkg::*;
#(
  parameter int CHROMA_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [TEMP_W-1:0] temperature_k,
  input  logic [LUM_W-1:0]  luminance_in,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [LUM_W-1:0]  luminance_out,
  output logic [OUT_W-1:0]  chroma_x,
  output logic [OUT_W-1:0]  chroma_y,
  output logic              in_range
);

  localparam int F  = CHROMA_FRAC_BITS;
  localparam int NV = UV_FRAC + F + 6;
  localparam int QW = (F > 16) ? F : 16;

  function automatic logic [OUT_W-1:0] sat16(input logic [F-1:0] q);
    logic [QW-1:0] e;
    e = QW'(q);
    return (e > QW'(16'hFFFF)) ? 16'hFFFF : e[OUT_W-1:0];
  endfunction

  logic adv;
  logic [NV-1:0] vld;
  logic [LUM_W-1:0] lum_p [NV];
  logic inr_p [NV];

  assign adv          = !(result_valid && result_stall);
  assign item_stall   = !adv;
  assign result_valid = vld[NV-1];
  assign luminance_out = lum_p[NV-1];
  assign in_range     = inr_p[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NV-2:0], item_valid};
    end
  end

  logic inr_now;
  assign inr_now = (temperature_k >= T_MIN) && (temperature_k <= T_MAX);

  always_ff @(posedge clk) begin
    if (adv) begin
      lum_p[0] <= inr_now ? luminance_in : '0;
      inr_p[0] <= inr_now;
      for (int i = 1; i < NV; i++) begin
        lum_p[i] <= lum_p[i-1];
        inr_p[i] <= inr_p[i-1];
      end
    end
  end

  // polynomial stages
  logic [TEMP_W-1:0] t0;
  logic [31:0] t2;
  logic [PW-1:0] un1t, ud1t, vn1t, vd1t;
  logic [PW-1:0] un1t2, ud1t2, vn1t2, vd1t2;
  logic [PW-1:0] un2t, ud2t, vn2t, vd2t;
  logic [PW-1:0] nu, du, nv, dv;

  always_ff @(posedge clk) begin
    if (adv) begin
      t0    <= temperature_k;
      t2    <= 32'(t0) * 32'(t0);
      un1t  <= UN1 * PW'(t0);
      ud1t  <= UD1 * PW'(t0);
      vn1t  <= VN1 * PW'(t0);
      vd1t  <= VD1 * PW'(t0);
      un2t  <= UN2 * PW'(t2);
      ud2t  <= UD2 * PW'(t2);
      vn2t  <= VN2 * PW'(t2);
      vd2t  <= VD2 * PW'(t2);
      un1t2 <= un1t;
      ud1t2 <= ud1t;
      vn1t2 <= vn1t;
      vd1t2 <= vd1t;
      nu    <= UN0 + un1t2 + un2t;
      du    <= SCALE_ONE + ud1t2 + ud2t;
      nv    <= VN0 + vn1t2 + vn2t;
      dv    <= SCALE_ONE + vd2t - vd1t2;
    end
  end

  // u and v: one quotient bit per stage
  logic [PW-1:0]      ur [UV_FRAC+1];
  logic [PW-1:0]      udn [UV_FRAC+1];
  logic [UV_FRAC-1:0] uq [UV_FRAC+1];
  logic [PW-1:0]      vr [UV_FRAC+1];
  logic [PW-1:0]      vdn [UV_FRAC+1];
  logic [UV_FRAC-1:0] vq [UV_FRAC+1];

  assign ur[0]  = nu;
  assign udn[0] = du;
  assign uq[0]  = '0;
  assign vr[0]  = nv;
  assign vdn[0] = dv;
  assign vq[0]  = '0;

  for (genvar k = 1; k <= UV_FRAC; k++) begin : g_uv
    logic [PW-1:0] us, vs;
    logic ub, vb;
    assign us = {ur[k-1][PW-2:0], 1'b0};
    assign vs = {vr[k-1][PW-2:0], 1'b0};
    assign ub = us >= udn[k-1];
    assign vb = vs >= vdn[k-1];
    always_ff @(posedge clk) begin
      if (adv) begin
        ur[k]  <= ub ? us - udn[k-1] : us;
        uq[k]  <= {uq[k-1][UV_FRAC-2:0], ub};
        udn[k] <= udn[k-1];
        vr[k]  <= vb ? vs - vdn[k-1] : vs;
        vq[k]  <= {vq[k-1][UV_FRAC-2:0], vb};
        vdn[k] <= vdn[k-1];
      end
    end
  end

  // denominator 6u - 24v + 12
  logic [DSW-1:0] dsum;
  logic dpos_now;
  assign dsum = DSW'(uq[UV_FRAC]) * DSW'(6) + D_TWELVE - DSW'(vq[UV_FRAC]) * DSW'(24);
  assign dpos_now = !dsum[DSW-1] && (dsum != '0);

  logic [DW-1:0] xr [F+1];
  logic [DW-1:0] yr [F+1];
  logic [DW-1:0] dd [F+1];
  logic [F-1:0]  xq [F+1];
  logic [F-1:0]  yq [F+1];
  logic          dp [F+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      xr[0] <= DW'(uq[UV_FRAC]) * DW'(9);
      yr[0] <= DW'(vq[UV_FRAC]) * DW'(6);
      dd[0] <= dsum[DW-1:0];
      dp[0] <= dpos_now;
    end
  end
  assign xq[0] = '0;
  assign yq[0] = '0;

  for (genvar k = 1; k <= F; k++) begin : g_xy
    logic [DW-1:0] xs, ys;
    logic xb, yb;
    assign xs = {xr[k-1][DW-2:0], 1'b0};
    assign ys = {yr[k-1][DW-2:0], 1'b0};
    assign xb = xs >= dd[k-1];
    assign yb = ys >= dd[k-1];
    always_ff @(posedge clk) begin
      if (adv) begin
        xr[k] <= xb ? xs - dd[k-1] : xs;
        xq[k] <= {xq[k-1][F-2:0], xb};
        yr[k] <= yb ? ys - dd[k-1] : ys;
        yq[k] <= {yq[k-1][F-2:0], yb};
        dd[k] <= dd[k-1];
        dp[k] <= dp[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chroma_x <= (inr_p[NV-2] && dp[F]) ? sat16(xq[F]) : '0;
      chroma_y <= (inr_p[NV-2] && dp[F]) ? sat16(yq[F]) : '0;
    end
  end

  // out-of-range beats carry all-zero payload
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !in_range |-> chroma_x == '0 && chroma_y == '0 && luminance_out == '0)
    else $error("out-of-range beat has nonzero payload");

  // in-range x is well above zero, so an all-zero x means a broken divide
  assert property (@(posedge clk) disable iff (rst)
    result_valid && in_range |-> chroma_x != '0)
    else $error("in-range beat has zero chroma_x");

  // a stalled result freezes the pipeline, so the final valid bit holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped under stall");

endmodule
